// ----- rtl/kta_pkg.sv -----
// Shared types and constants for the key-to-row allocator.
`default_nettype none

package kta_pkg;

  localparam int ROW_CAPACITY_DEF = 64;

  localparam int KEY_W    = 64;
  localparam int ROW_W    = 6;
  localparam int STATUS_W = 3;
  localparam int LIVE_W   = 7;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_REUSED   = 3'd1,
    ST_APPENDED = 3'd2,
    ST_DELETED  = 3'd3,
    ST_ABSENT   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef struct packed {
    logic             live;
    logic             freed;
    logic [KEY_W-1:0] key;
  } row_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/kta_if.sv -----
// Request and response channel interfaces for the key-to-row allocator.
`default_nettype none

interface kta_req_if;
  import kta_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface kta_rsp_if;
  import kta_pkg::*;

  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    row_index;
  logic [STATUS_W-1:0] status;
  logic [LIVE_W-1:0]   live_rows;

  modport source (output valid, output row_index, output status, output live_rows,
                  input ready);
  modport sink   (input valid, input row_index, input status, input live_rows,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/kta_row_mem.sv -----
// Row table memory: key plus live and freed flags, one write and one registered read port.
`default_nettype none

module kta_row_mem #(
  parameter int   DEPTH = kta_pkg::ROW_CAPACITY_DEF,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  kta_pkg::row_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output kta_pkg::row_entry_t rd_data
);
  import kta_pkg::*;

  row_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/key_to_row_allocator.sv -----
// Key-to-row allocator top level: sequencer, scan compare and row bookkeeping.
//
//   channel | dir | word                          | accepted when
//   req     | in  | kind, key                     | req.valid && req.ready
//   rsp     | out | row_index, status, live_rows  | rsp.valid && rsp.ready
//
// An item goes from the accept cycle through a scan state, which makes one row
// table read per cycle through the single read port for each appended row, a drain
// state, then a decide state; scan and drain are skipped with no row appended.
// req.ready is high only in idle; decide waits while the previous word is unread, and
// a finished word waits in the output register while the next request is taken.
// Reset clears counters, not rows; rows at or above the append count are never used.
`default_nettype none

module key_to_row_allocator #(
  parameter int ROW_CAPACITY = kta_pkg::ROW_CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  kta_req_if.sink    req,
  kta_rsp_if.source  rsp
);
  import kta_pkg::*;

  localparam int RW = $clog2(ROW_CAPACITY);
  localparam int CW = $clog2(ROW_CAPACITY + 1);

  state_t state, state_next;

  logic             kind_q;
  logic [KEY_W-1:0] key_q;
  logic [RW-1:0]    scan_addr;
  logic             chk_valid;
  logic [RW-1:0]    chk_row;
  logic             hit_found;
  logic [RW-1:0]    hit_row;
  logic             free_found;
  logic [RW-1:0]    free_row;
  logic [CW-1:0]    rows_allocated;
  logic [CW-1:0]    live_count;

  logic             rsp_valid;
  logic [ROW_W-1:0] rsp_row;
  status_t          rsp_status;
  logic [LIVE_W-1:0] rsp_live;

  row_entry_t    rd_data;
  logic          wr_en;
  logic [RW-1:0] wr_addr;
  row_entry_t    wr_data;

  logic          accept;
  logic          scan_last;
  logic          do_decide;
  logic [RW-1:0] res_row;
  status_t       res_status;
  logic          alloc_inc;
  logic [CW-1:0] live_next;
  logic [RW+ROW_W-1:0]  row_ext;
  logic [CW+LIVE_W-1:0] live_ext;

  kta_row_mem #(.DEPTH(ROW_CAPACITY)) u_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  assign accept    = req.valid && req.ready;
  assign scan_last = (CW'(scan_addr) == rows_allocated - CW'(1));
  assign do_decide = (state == S_DECIDE) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = (rows_allocated == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outcome of the scan, table write and counter updates
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = rows_allocated[RW-1:0];
    wr_data    = '{live: 1'b1, freed: 1'b0, key: key_q};
    res_row    = '0;
    res_status = ST_FULL;
    alloc_inc  = 1'b0;
    live_next  = live_count;
    if (kind_q == KIND_DELETE) begin
      if (hit_found) begin
        wr_en      = do_decide;
        wr_addr    = hit_row;
        wr_data    = '{live: 1'b0, freed: 1'b1, key: key_q};
        res_row    = hit_row;
        res_status = ST_DELETED;
        live_next  = live_count - CW'(1);
      end else begin
        res_status = ST_ABSENT;
      end
    end else begin
      if (hit_found) begin
        res_row    = hit_row;
        res_status = ST_FOUND;
      end else if (free_found) begin
        wr_en      = do_decide;
        wr_addr    = free_row;
        res_row    = free_row;
        res_status = ST_REUSED;
        live_next  = live_count + CW'(1);
      end else if (rows_allocated < CW'(ROW_CAPACITY)) begin
        wr_en      = do_decide;
        res_row    = rows_allocated[RW-1:0];
        res_status = ST_APPENDED;
        alloc_inc  = 1'b1;
        live_next  = live_count + CW'(1);
      end
    end
  end

  assign row_ext  = (RW + ROW_W)'(res_row);
  assign live_ext = (CW + LIVE_W)'(live_next);

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= req.kind;
      key_q  <= req.key;
    end
    chk_row <= scan_addr;
    if (do_decide) begin
      rsp_row    <= row_ext[ROW_W-1:0];
      rsp_status <= res_status;
      rsp_live   <= live_ext[LIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr      <= '0;
      chk_valid      <= 1'b0;
      hit_found      <= 1'b0;
      hit_row        <= '0;
      free_found     <= 1'b0;
      free_row       <= '0;
      rows_allocated <= '0;
      live_count     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      chk_valid <= (state == S_SCAN);
      if (accept) begin
        scan_addr  <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (state == S_SCAN) begin
          scan_addr <= scan_addr + RW'(1);
        end
        if (chk_valid) begin
          if (rd_data.live && (rd_data.key == key_q) && !hit_found) begin
            hit_found <= 1'b1;
            hit_row   <= chk_row;
          end
          if (rd_data.freed && !free_found) begin
            free_found <= 1'b1;
            free_row   <= chk_row;
          end
        end
      end
      if (do_decide) begin
        live_count <= live_next;
        if (alloc_inc) begin
          rows_allocated <= rows_allocated + CW'(1);
        end
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.row_index = rsp_row;
  assign rsp.status    = rsp_status;
  assign rsp.live_rows = rsp_live;

`ifndef ASSERT_OFF
  a_live_le_alloc: assert property (@(posedge clk) disable iff (rst)
    live_count <= rows_allocated)
    else $error("live row count exceeds appended rows");

  a_alloc_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> rows_allocated >= $past(rows_allocated))
    else $error("append count went down");

  a_full_only_when_exhausted: assert property (@(posedge clk) disable iff (rst)
    do_decide && (res_status == ST_FULL) |->
      (rows_allocated == CW'(ROW_CAPACITY)) && !free_found)
    else $error("full reported with rows available");

  a_rsp_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DECIDE)
    else $error("response raised outside decide");

  a_no_write_while_scanning: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_DRAIN) |-> !wr_en)
    else $error("row table written during scan");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_key_to_row_allocator.sv -----
// Self-checking testbench for the key-to-row allocator: directed, full-table, back-pressure and random traffic.
`default_nettype none

module tb_key_to_row_allocator;
  import kta_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS       = ROW_CAPACITY_DEF;
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int SETTLE_CYC = ROWS + 8;
  localparam int POOL_MAX   = 128;

  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    status_t           status;
    logic [LIVE_W-1:0] live_rows;
  } alloc_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kta_req_if req_ch ();
  kta_rsp_if rsp_ch ();

  key_to_row_allocator #(.ROW_CAPACITY(ROWS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // Shadow copy of the row table
  logic [KEY_W-1:0] shadow_key   [ROWS];
  logic             shadow_live  [ROWS];
  logic             shadow_freed [ROWS];
  int               shadow_alloc;

  alloc_word_t      pending_words[$];
  logic [KEY_W-1:0] key_pool[POOL_MAX];

  int fail_count   = 0;
  int report_count = 0;
  int cycle_count  = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len   = 0;
  int hold_token = 0;
  int hold_ack   = 0;
  int hold_left  = 0;

  function automatic alloc_word_t allocate_row(input kind_t kind, input logic [KEY_W-1:0] key);
    alloc_word_t w;
    int hit;
    int fr;
    int n;
    hit = -1;
    fr  = -1;
    n   = 0;
    for (int r = 0; r < ROWS; r++) begin
      if (hit < 0 && shadow_live[r] && shadow_key[r] == key) hit = r;
      if (fr < 0 && shadow_freed[r]) fr = r;
    end
    w.row_index = '0;
    if (kind == KIND_INSERT) begin
      if (hit >= 0) begin
        w.row_index = hit[ROW_W-1:0];
        w.status    = ST_FOUND;
      end else if (fr >= 0) begin
        shadow_freed[fr] = 1'b0;
        shadow_live[fr]  = 1'b1;
        shadow_key[fr]   = key;
        w.row_index      = fr[ROW_W-1:0];
        w.status         = ST_REUSED;
      end else if (shadow_alloc < ROWS) begin
        shadow_live[shadow_alloc] = 1'b1;
        shadow_key[shadow_alloc]  = key;
        w.row_index               = shadow_alloc[ROW_W-1:0];
        w.status                  = ST_APPENDED;
        shadow_alloc++;
      end else begin
        w.status = ST_FULL;
      end
    end else begin
      if (hit >= 0) begin
        shadow_live[hit]  = 1'b0;
        shadow_freed[hit] = 1'b1;
        w.row_index       = hit[ROW_W-1:0];
        w.status          = ST_DELETED;
      end else begin
        w.status = ST_ABSENT;
      end
    end
    for (int r = 0; r < ROWS; r++) n += shadow_live[r] ? 1 : 0;
    w.live_rows = n[LIVE_W-1:0];
    return w;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input kind_t kind, input logic [KEY_W-1:0] key);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.key   <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_words = {pending_words, allocate_row(kind, key)};
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_pace(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic test_directed();
    set_pace(0, 0);
    send_word(KIND_INSERT, 64'h0);
    send_word(KIND_INSERT, '1);
    send_word(KIND_INSERT, 64'h0);
    send_word(KIND_INSERT, '1);
    send_word(KIND_DELETE, 64'h1);
    send_word(KIND_DELETE, 64'h0);
    send_word(KIND_DELETE, 64'h0);
    send_word(KIND_INSERT, 64'h8000_0000_0000_0000);
    send_word(KIND_INSERT, 64'h5555_5555_5555_5555);
    send_word(KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(KIND_DELETE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(KIND_DELETE, 64'h5555_5555_5555_5555);
    send_word(KIND_INSERT, 64'h1);
    send_word(KIND_INSERT, 64'h2);
    send_word(KIND_INSERT, 64'h0);
    send_word(KIND_DELETE, '1);
    send_word(KIND_DELETE, 64'h8000_0000_0000_0000);
    send_word(KIND_DELETE, 64'h1);
    send_word(KIND_DELETE, 64'h2);
    send_word(KIND_DELETE, 64'h0);
    send_word(KIND_INSERT, '1);
    send_word(KIND_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
    wait_drained();
  endtask

  task automatic test_full_table();
    logic [KEY_W-1:0] filled[$];
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] doomed[$];
    set_pace(28, 28);
    for (int i = 0; i < ROWS + 6; i++) begin
      k = fresh_key();
      filled = {filled, k};
      send_word(KIND_INSERT, k);
    end
    send_word(KIND_INSERT, filled[5]);
    send_word(KIND_INSERT, fresh_key());
    send_word(KIND_DELETE, filled[40]);
    send_word(KIND_DELETE, filled[10]);
    send_word(KIND_DELETE, fresh_key());
    send_word(KIND_INSERT, fresh_key());
    send_word(KIND_INSERT, fresh_key());
    send_word(KIND_INSERT, fresh_key());
    wait_drained();
    // empty the table so the next phase starts from freed rows only
    for (int r = 0; r < ROWS; r++) if (shadow_live[r]) doomed = {doomed, shadow_key[r]};
    doomed.shuffle();
    foreach (doomed[i]) send_word(KIND_DELETE, doomed[i]);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_pace(0, 0);
    hold_len   = 600;
    hold_token <= hold_token + 1;
    for (int i = 0; i < 16; i++) begin
      send_word((i % 3 == 2) ? KIND_DELETE : KIND_INSERT, key_pool[$urandom_range(7)]);
    end
    wait_drained();
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct,
                             input int pool_size);
    kind_t kind;
    logic [KEY_W-1:0] key;
    for (int i = 2; i < pool_size; i++) key_pool[i] = fresh_key();
    key_pool[0] = '0;
    key_pool[1] = '1;
    set_pace(send_pct, recv_pct);
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(99) < 55) ? KIND_INSERT : KIND_DELETE;
      if ($urandom_range(99) < 5) key = fresh_key();
      else key = key_pool[$urandom_range(pool_size - 1)];
      send_word(kind, key);
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("key_to_row_allocator test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_token != hold_ack) begin
      hold_left <= hold_len;
      hold_ack  <= hold_token;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= (hold_token == hold_ack) && (hold_left == 0) &&
                    ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    alloc_word_t exp_w;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        fail_count++;
        if (report_count < 10) begin
          report_count++;
          $display("unexpected word: row %0d status %0d live %0d",
                   rsp_ch.row_index, rsp_ch.status, rsp_ch.live_rows);
        end
      end else begin
        exp_w = pending_words.pop_front();
        if (rsp_ch.row_index !== exp_w.row_index || rsp_ch.status !== exp_w.status ||
            rsp_ch.live_rows !== exp_w.live_rows) begin
          fail_count++;
          if (report_count < 10) begin
            report_count++;
            $display({"mismatch: expected row %0d status %0d live %0d, ",
                      "got row %0d status %0d live %0d"},
                     exp_w.row_index, exp_w.status, exp_w.live_rows,
                     rsp_ch.row_index, rsp_ch.status, rsp_ch.live_rows);
          end
        end
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_INSERT;
    req_ch.key   = '0;
    rsp_ch.ready = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      shadow_key[r]   = '0;
      shadow_live[r]  = 1'b0;
      shadow_freed[r] = 1'b0;
    end
    shadow_alloc = 0;
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = fresh_key();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_table();
    test_backpressure();
    test_random(305, 0, 0, 48);
    test_random(305, 86, 0, 96);
    test_random(305, 0, 86, 48);
    test_random(305, 28, 28, 96);

    if (pending_words.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("key_to_row_allocator test passed");
    end else begin
      $display("key_to_row_allocator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
